FILE: hw/rtl/tmv4_pkg.sv
// ----------------------------------------------------------------------------
// tmv4_pkg
// Shared types, constants and helpers for the transposed matrix-vector block.
// ----------------------------------------------------------------------------
`default_nettype none

package tmv4_pkg;

  localparam int unsigned Cols          = 4;
  localparam int unsigned LanesDefault  = 4;
  localparam int unsigned FracDefault   = 16;
  localparam int unsigned FifoDepth     = 8;
  localparam int unsigned DataW         = 32;
  localparam int unsigned AccW          = 64;
  localparam int unsigned ColW          = 3;
  localparam int unsigned CfgIdxW       = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegAlpha   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegBeta    = 2'd1;
  localparam logic [CfgIdxW-1:0] RegColumns = 2'd2;

  localparam logic [ColW-1:0] ColumnsReset = 3'd4;

  typedef struct packed {
    logic signed [DataW-1:0] a_col0;
    logic signed [DataW-1:0] a_col1;
    logic signed [DataW-1:0] a_col2;
    logic signed [DataW-1:0] a_col3;
    logic signed [DataW-1:0] x_value;
    logic signed [DataW-1:0] y_lane0;
    logic signed [DataW-1:0] y_lane1;
    logic signed [DataW-1:0] y_lane2;
    logic signed [DataW-1:0] y_lane3;
    logic                    last_row;
  } in_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] z_lane0;
    logic signed [DataW-1:0] z_lane1;
    logic signed [DataW-1:0] z_lane2;
    logic signed [DataW-1:0] z_lane3;
    logic                    overflow;
  } out_item_t;

  // control seen by one accumulator lane in the accumulate stage
  typedef struct packed {
    logic valid;
    logic last;
    logic active;
  } acc_ctl_t;

  // column counts other than one to three mean four columns
  function automatic logic [ColW-1:0] num_cols(input logic [ColW-1:0] cfg);
    logic [ColW-1:0] n;
    n = ColumnsReset;
    if (cfg >= 3'd1 && cfg <= 3'd3) begin
      n = cfg;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/transposed_matvec_4col_top.sv
// ----------------------------------------------------------------------------
// transposed_matvec_4col_top
// z = alpha * A^T * x + beta * y over up to four columns, Q16.16 data.
//
// Input channel (in_valid_i / in_stall_o / in_item_i): one matrix row with
// its x element per item; y elements are used on the row marked last_row.
// Output channel (out_valid_o / out_stall_i / out_item_o): one result item
// per last row, lanes at or above the column count read zero.
// Config channel (cfg_valid_i / cfg_ready_o): index 0 alpha, 1 beta,
// 2 active_columns; always ready; write only while the block is idle.
// Throughput: one row per cycle while in_stall_o is low, set by the
// per-lane multiplier feeding the accumulator every cycle. A result is
// presented once its last row has passed the product register (loaded on
// the accepting edge), accumulate, scaling multiply, sum and queue write.
// Once 8 results are pending, in_stall_o stays high until the receiver
// takes one. A stalled output holds its item.
// Reset clears accumulators, overflow flag and queue, and loads alpha 1.0,
// beta 0, four columns.
// ----------------------------------------------------------------------------
`default_nettype none

module transposed_matvec_4col_top #(
  parameter int unsigned LANES     = tmv4_pkg::LanesDefault,
  parameter int unsigned FRAC_BITS = tmv4_pkg::FracDefault
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire tmv4_pkg::in_item_t                 in_item_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output tmv4_pkg::out_item_t                     out_item_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [tmv4_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  wire logic [tmv4_pkg::DataW-1:0]         cfg_data_i
);

  localparam int unsigned Used  = (LANES < tmv4_pkg::Cols) ? LANES : tmv4_pkg::Cols;
  localparam int unsigned PendW = $clog2(tmv4_pkg::FifoDepth + 1);

  // configuration
  logic signed [tmv4_pkg::DataW-1:0] alpha_q, beta_q;
  logic [tmv4_pkg::ColW-1:0]         columns_q;
  logic [tmv4_pkg::ColW-1:0]         ncol;
  logic                              cfg_fire;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q   <= tmv4_pkg::DataW'(64'd1 << FRAC_BITS);
      beta_q    <= '0;
      columns_q <= tmv4_pkg::ColumnsReset;
    end else if (cfg_fire) begin
      case (cfg_index_i)
        tmv4_pkg::RegAlpha:   alpha_q   <= cfg_data_i;
        tmv4_pkg::RegBeta:    beta_q    <= cfg_data_i;
        tmv4_pkg::RegColumns: columns_q <= cfg_data_i[tmv4_pkg::ColW-1:0];
        default: ;
      endcase
    end
  end

  assign ncol = tmv4_pkg::num_cols(columns_q);

  // input side
  logic in_fire;
  logic [PendW-1:0] pend_q, pend_d;
  logic out_fire;

  assign in_stall_o = (pend_q == PendW'(tmv4_pkg::FifoDepth));
  assign in_fire    = in_valid_i && !in_stall_o;

  logic signed [tmv4_pkg::DataW-1:0] a_col [tmv4_pkg::Cols];
  logic signed [tmv4_pkg::DataW-1:0] y_in  [tmv4_pkg::Cols];

  assign a_col[0] = in_item_i.a_col0;
  assign a_col[1] = in_item_i.a_col1;
  assign a_col[2] = in_item_i.a_col2;
  assign a_col[3] = in_item_i.a_col3;
  assign y_in[0]  = in_item_i.y_lane0;
  assign y_in[1]  = in_item_i.y_lane1;
  assign y_in[2]  = in_item_i.y_lane2;
  assign y_in[3]  = in_item_i.y_lane3;

  // pipeline control: product, final capture, multiply, sum
  logic p_valid_q, p_last_q;
  logic f_valid_q, f_ovf_q;
  logic m_valid_q, m_ovf_q;
  logic s_valid_q, s_ovf_q;
  logic sticky_q;

  logic [Used-1:0]                   lane_active;
  logic [Used-1:0]                   acc_sat;
  logic [Used-1:0]                   res_sat;
  logic signed [tmv4_pkg::DataW-1:0] z_lane [tmv4_pkg::Cols];

  for (genvar i = 0; i < Used; i++) begin : g_lane
    tmv4_pkg::acc_ctl_t                ctl;
    logic signed [tmv4_pkg::AccW-1:0]  fin_acc;
    logic signed [tmv4_pkg::DataW-1:0] fin_y;
    logic signed [tmv4_pkg::DataW-1:0] z;
    logic                              sat;

    assign lane_active[i] = (tmv4_pkg::ColW'(i) < ncol);
    assign ctl.valid  = p_valid_q;
    assign ctl.last   = p_last_q;
    assign ctl.active = lane_active[i];

    tmv4_mac_lane u_mac (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .in_fire_i (in_fire),
      .a_i       (a_col[i]),
      .x_i       (in_item_i.x_value),
      .y_i       (y_in[i]),
      .ctl_i     (ctl),
      .sat_o     (acc_sat[i]),
      .fin_acc_o (fin_acc),
      .fin_y_o   (fin_y)
    );

    tmv4_scale_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_scale (
      .clk_i   (clk_i),
      .alpha_i (alpha_q),
      .beta_i  (beta_q),
      .acc_i   (fin_acc),
      .y_i     (fin_y),
      .z_o     (z),
      .sat_o   (sat)
    );

    assign res_sat[i] = sat && lane_active[i];
    assign z_lane[i]  = lane_active[i] ? z : '0;
  end

  for (genvar i = Used; i < tmv4_pkg::Cols; i++) begin : g_unused
    assign z_lane[i] = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      p_last_q  <= 1'b0;
      f_valid_q <= 1'b0;
      f_ovf_q   <= 1'b0;
      m_valid_q <= 1'b0;
      m_ovf_q   <= 1'b0;
      s_valid_q <= 1'b0;
      s_ovf_q   <= 1'b0;
      sticky_q  <= 1'b0;
    end else begin
      p_valid_q <= in_fire;
      p_last_q  <= in_item_i.last_row;
      f_valid_q <= p_valid_q && p_last_q;
      f_ovf_q   <= sticky_q || (|acc_sat);
      m_valid_q <= f_valid_q;
      m_ovf_q   <= f_ovf_q;
      s_valid_q <= m_valid_q;
      s_ovf_q   <= m_ovf_q;
      if (p_valid_q) begin
        sticky_q <= p_last_q ? 1'b0 : (sticky_q || (|acc_sat));
      end
    end
  end

  // merge lanes into one result item
  tmv4_pkg::out_item_t res;

  always_comb begin
    res.z_lane0  = z_lane[0];
    res.z_lane1  = z_lane[1];
    res.z_lane2  = z_lane[2];
    res.z_lane3  = z_lane[3];
    res.overflow = s_ovf_q || (|res_sat);
  end

  assign out_fire = out_valid_o && !out_stall_i;

  tmv4_out_fifo #(
    .DEPTH (tmv4_pkg::FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s_valid_q),
    .data_i  (res),
    .pop_i   (out_fire),
    .valid_o (out_valid_o),
    .data_o  (out_item_o)
  );

  // results accepted but not yet delivered, bounds the queue
  always_comb begin
    pend_d = pend_q;
    if ((in_fire && in_item_i.last_row) && !out_fire) begin
      pend_d = pend_q + 1'b1;
    end else if (out_fire && !(in_fire && in_item_i.last_row)) begin
      pend_d = pend_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/tmv4_mac_lane.sv
// ----------------------------------------------------------------------------
// tmv4_mac_lane
// One column lane: registered a*x product, saturating 64-bit accumulator,
// and capture of the final sum and y element on the last row.
// ----------------------------------------------------------------------------
`default_nettype none

module tmv4_mac_lane (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_fire_i,
  input  wire logic signed [tmv4_pkg::DataW-1:0]    a_i,
  input  wire logic signed [tmv4_pkg::DataW-1:0]    x_i,
  input  wire logic signed [tmv4_pkg::DataW-1:0]    y_i,
  input  wire tmv4_pkg::acc_ctl_t                   ctl_i,
  output logic                                      sat_o,
  output logic signed [tmv4_pkg::AccW-1:0]          fin_acc_o,
  output logic signed [tmv4_pkg::DataW-1:0]         fin_y_o
);

  logic signed [tmv4_pkg::AccW-1:0]  prod_q;
  logic signed [tmv4_pkg::DataW-1:0] y_q;
  logic signed [tmv4_pkg::AccW-1:0]  acc_q, acc_d;
  logic signed [tmv4_pkg::AccW-1:0]  sum;
  logic signed [tmv4_pkg::AccW-1:0]  sum_sat;
  logic                              sat;

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      prod_q <= a_i * x_i;
      y_q    <= y_i;
    end
  end

  always_comb begin
    sum = acc_q + prod_q;
    sat = (acc_q[tmv4_pkg::AccW-1] == prod_q[tmv4_pkg::AccW-1]) &&
          (sum[tmv4_pkg::AccW-1] != acc_q[tmv4_pkg::AccW-1]);
    sum_sat = sum;
    if (sat) begin
      sum_sat = acc_q[tmv4_pkg::AccW-1] ? {1'b1, {(tmv4_pkg::AccW-1){1'b0}}}
                                        : {1'b0, {(tmv4_pkg::AccW-1){1'b1}}};
    end
  end

  assign sat_o = ctl_i.valid && ctl_i.active && sat;

  always_comb begin
    acc_d = acc_q;
    if (ctl_i.valid) begin
      if (ctl_i.last) begin
        acc_d = '0;
      end else if (ctl_i.active) begin
        acc_d = sum_sat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.valid && ctl_i.last) begin
      fin_acc_o <= ctl_i.active ? sum_sat : '0;
      fin_y_o   <= y_q;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/tmv4_scale_lane.sv
// ----------------------------------------------------------------------------
// tmv4_scale_lane
// Output scaling for one lane: alpha*acc + (beta*y << FRAC_BITS), floor
// shift by 2*FRAC_BITS and saturation to 32 bits. Two register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module tmv4_scale_lane #(
  parameter int unsigned FRAC_BITS = tmv4_pkg::FracDefault
) (
  input  wire logic                                 clk_i,
  input  wire logic signed [tmv4_pkg::DataW-1:0]    alpha_i,
  input  wire logic signed [tmv4_pkg::DataW-1:0]    beta_i,
  input  wire logic signed [tmv4_pkg::AccW-1:0]     acc_i,
  input  wire logic signed [tmv4_pkg::DataW-1:0]    y_i,
  output logic signed [tmv4_pkg::DataW-1:0]         z_o,
  output logic                                      sat_o
);

  localparam int unsigned HalfW = tmv4_pkg::AccW / 2;
  localparam int unsigned VW    = tmv4_pkg::DataW + tmv4_pkg::AccW + 1;
  localparam int unsigned Shift = 2 * FRAC_BITS;

  logic signed [tmv4_pkg::AccW-1:0]   mh_q;   // alpha * acc upper half
  logic signed [tmv4_pkg::AccW:0]     ml_q;   // alpha * acc lower half (unsigned)
  logic signed [tmv4_pkg::AccW-1:0]   by_q;
  logic signed [VW-1:0]               v_d, v_q;
  logic signed [VW-1:0]               sh;
  logic [VW-tmv4_pkg::DataW:0]        top_bits;
  logic                               fits;

  // acc split in halves to keep each multiplier near 32x32
  always_ff @(posedge clk_i) begin
    mh_q <= alpha_i * $signed(acc_i[tmv4_pkg::AccW-1:HalfW]);
    ml_q <= alpha_i * $signed({1'b0, acc_i[HalfW-1:0]});
    by_q <= beta_i * y_i;
  end

  always_comb begin
    v_d = (VW'(mh_q) <<< HalfW) + VW'(ml_q) + (VW'(by_q) <<< FRAC_BITS);
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
  end

  always_comb begin
    sh       = v_q >>> Shift;
    top_bits = sh[VW-1:tmv4_pkg::DataW-1];
    fits     = (&top_bits) || !(|top_bits);
    sat_o    = !fits;
    if (fits) begin
      z_o = sh[tmv4_pkg::DataW-1:0];
    end else if (sh[VW-1]) begin
      z_o = {1'b1, {(tmv4_pkg::DataW-1){1'b0}}};
    end else begin
      z_o = {1'b0, {(tmv4_pkg::DataW-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/tmv4_out_fifo.sv
// ----------------------------------------------------------------------------
// tmv4_out_fifo
// Small result queue between the scaling pipeline and the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module tmv4_out_fifo #(
  parameter int unsigned DEPTH = tmv4_pkg::FifoDepth
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire tmv4_pkg::out_item_t  data_i,
  input  wire logic                 pop_i,
  output logic                      valid_o,
  output tmv4_pkg::out_item_t       data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  tmv4_pkg::out_item_t mem_q [DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

endmodule

`default_nettype wire

FILE: test/transposed_matvec_4col_top_tb.sv
// ----------------------------------------------------------------------------
// transposed_matvec_4col_top_tb
// Self-checking bench for the four-column transposed matrix-vector block.
//
// Matrix rows stream in through a queue-fed driver, and a clocked monitor
// takes the result items. A bit-exact predictor checks every result field
// against the oldest expectation. It models the Q32.32 lane accumulators,
// the alpha/beta scaling and the saturation and overflow rules.
// Directed rows cover the data extremes, accumulator saturation in both
// directions, the zero-beta case and each column count. Random phases then
// change the registers between runs of random matrices. Both sides idle in
// random bursts, and in one phase the receiver holds off long enough to
// back up the block.
// ----------------------------------------------------------------------------
module transposed_matvec_4col_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tmv4_pkg::*;

  localparam logic [CfgIdxW-1:0] RegSpare = 2'd3;  // unmapped index, must be ignored
  localparam logic [DataW-1:0] QOne    = 32'h0001_0000;
  localparam logic [DataW-1:0] QNegOne = 32'hFFFF_0000;
  localparam logic [DataW-1:0] QMax    = 32'h7FFF_FFFF;
  localparam logic [DataW-1:0] QMin    = 32'h8000_0000;
  localparam logic signed [127:0] ZMax = 128'sh7FFF_FFFF;
  localparam logic signed [127:0] ZMin = {{96{1'b1}}, 32'h8000_0000};
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned LimitCycles = 200_000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_item_t            in_item = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_item;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [DataW-1:0]    cfg_data = '0;

  transposed_matvec_4col_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic signed [AccW-1:0]  lane_acc [Cols];
  bit                      acc_sat;
  logic signed [DataW-1:0] alpha_q;
  logic signed [DataW-1:0] beta_q;
  logic [ColW-1:0]         cols_cfg;

  in_item_t    pending_rows [$];
  out_item_t   z_expected [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          long_hold_req = 1'b0;
  int unsigned fail_count = 0;
  int unsigned rows_sent = 0;
  int unsigned results_seen = 0;
  int unsigned sat_results = 0;
  int unsigned reg_writes = 0;
  int unsigned cycle_count = 0;

  // one row through the MAC lanes; a last row also yields the scaled result
  task automatic mac_row(input in_item_t row, output bit emits, output out_item_t z);
    logic signed [DataW-1:0] a_el [Cols];
    logic signed [DataW-1:0] y_el [Cols];
    logic signed [DataW-1:0] z_el [Cols];
    logic signed [AccW-1:0]  prod;
    logic signed [AccW-1:0]  sum;
    logic signed [127:0]     wide;
    logic signed [127:0]     yterm;
    logic signed [127:0]     shifted;
    int unsigned             ncol;
    bit                      sat;
    a_el = '{row.a_col0, row.a_col1, row.a_col2, row.a_col3};
    y_el = '{row.y_lane0, row.y_lane1, row.y_lane2, row.y_lane3};
    ncol = (cols_cfg >= 3'd1 && cols_cfg <= 3'd3) ? cols_cfg : 4;
    for (int i = 0; i < Cols; i++) begin
      if (i < ncol) begin
        prod = $signed(a_el[i]) * $signed(row.x_value);
        sum  = lane_acc[i] + prod;
        if (lane_acc[i][AccW-1] == prod[AccW-1] && sum[AccW-1] != prod[AccW-1]) begin
          sum = prod[AccW-1] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
          acc_sat = 1'b1;
        end
        lane_acc[i] = sum;
      end
    end
    emits = row.last_row;
    z = '0;
    if (emits) begin
      sat = acc_sat;
      for (int i = 0; i < Cols; i++) begin
        z_el[i] = '0;
        if (i < ncol) begin
          wide = alpha_q;
          wide = wide * lane_acc[i];
          if (beta_q != 0) begin
            yterm = beta_q;
            yterm = yterm * y_el[i];
            wide  = wide + (yterm <<< FracDefault);
          end
          shifted = wide >>> (2 * FracDefault);
          if (shifted > ZMax) begin
            z_el[i] = QMax;
            sat = 1'b1;
          end else if (shifted < ZMin) begin
            z_el[i] = QMin;
            sat = 1'b1;
          end else begin
            z_el[i] = shifted[DataW-1:0];
          end
        end
      end
      z.z_lane0  = z_el[0];
      z.z_lane1  = z_el[1];
      z.z_lane2  = z_el[2];
      z.z_lane3  = z_el[3];
      z.overflow = sat;
      for (int i = 0; i < Cols; i++) lane_acc[i] = '0;
      acc_sat = 1'b0;
    end
  endtask

  // ---------------- driver ----------------
  int unsigned send_gap;

  always @(posedge clk_i or negedge rst_ni) begin
    bit        emits;
    out_item_t z;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_item  <= '0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        mac_row(in_item, emits, z);
        if (emits) z_expected.push_back(z);
        rows_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_rows.size() != 0 &&
                     $urandom_range(0, 99) >= send_idle_pct) begin
          in_item  <= pending_rows.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
          if (pending_rows.size() != 0) send_gap = $urandom_range(0, 4);
        end
      end
    end
  end

  // ---------------- monitor ----------------
  int unsigned recv_gap;
  int unsigned hold_left;
  bit          hold_used;

  task automatic report(input string what, input logic [DataW-1:0] want,
                        input logic [DataW-1:0] got);
    fail_count++;
    $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
  endtask

  task automatic check_z(input out_item_t got);
    out_item_t         want;
    logic [DataW-1:0]  want_l [Cols];
    logic [DataW-1:0]  got_l [Cols];
    if (z_expected.size() == 0) begin
      fail_count++;
      $display("%0t: result item with none expected, actual %h", $time, got);
    end else begin
      want = z_expected.pop_front();
      results_seen++;
      if (want.overflow) sat_results++;
      want_l = '{want.z_lane0, want.z_lane1, want.z_lane2, want.z_lane3};
      got_l  = '{got.z_lane0, got.z_lane1, got.z_lane2, got.z_lane3};
      for (int i = 0; i < Cols; i++)
        if (got_l[i] !== want_l[i]) report($sformatf("z_lane%0d", i), want_l[i], got_l[i]);
      if (got.overflow !== want.overflow) report("overflow", want.overflow, got.overflow);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      recv_gap = 0;
      hold_left = 0;
      hold_used = 1'b0;
    end else begin
      if (out_valid && !out_stall) check_z(out_item);
      if (long_hold_req && !hold_used && out_valid) begin
        hold_used = 1'b1;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < recv_idle_pct) begin
        recv_gap = $urandom_range(0, 4);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------- watchdog ----------------
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LimitCycles) begin
      $display("transposed_matvec_4col_top regression: fail");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  function automatic logic [DataW-1:0] rand_elem(input bit wild);
    int signed small_v;
    small_v = int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
    case ($urandom_range(0, wild ? 9 : 39))
      0:       return QMin;
      1:       return QMax;
      2:       return $urandom_range(0, 1) ? '0 : '1;
      3, 4:    return $urandom;
      default: return small_v;
    endcase
  endfunction

  function automatic logic [DataW-1:0] rand_gain();
    int signed small_v;
    small_v = int'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    case ($urandom_range(0, 7))
      0:       return QMin;
      1:       return QMax;
      2:       return '0;
      3:       return $urandom;
      default: return small_v;
    endcase
  endfunction

  function automatic in_item_t row_of(
      input logic [DataW-1:0] a0, a1, a2, a3, x,
      input logic [DataW-1:0] y0, y1, y2, y3, input logic last);
    in_item_t r;
    r = '{a_col0: a0, a_col1: a1, a_col2: a2, a_col3: a3, x_value: x,
          y_lane0: y0, y_lane1: y1, y_lane2: y2, y_lane3: y3, last_row: last};
    return r;
  endfunction

  function automatic in_item_t rand_row(input bit wild, input logic last);
    return row_of(rand_elem(wild), rand_elem(wild), rand_elem(wild), rand_elem(wild),
                  rand_elem(wild), rand_elem(wild), rand_elem(wild), rand_elem(wild),
                  rand_elem(wild), last);
  endfunction

  // queue one random matrix, returns its row count
  function automatic int unsigned push_matrix(input int unsigned max_rows, input bit wild);
    int unsigned nrows;
    nrows = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 24) : $urandom_range(1, max_rows);
    for (int unsigned r = 1; r <= nrows; r++) pending_rows.push_back(rand_row(wild, r == nrows));
    return nrows;
  endfunction

  // sender and receiver finished, pipeline flushed
  task automatic drain();
    while (pending_rows.size() != 0 || in_valid || z_expected.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] data);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    reg_writes++;
    case (idx)
      RegAlpha:   alpha_q = data;
      RegBeta:    beta_q = data;
      RegColumns: cols_cfg = data[ColW-1:0];
      default:    ;
    endcase
  endtask

  initial begin
    logic [ColW-1:0] col_sweep [6];
    int unsigned     queued;
    col_sweep = '{3'd0, 3'd5, 3'd6, 3'd7, 3'd2, 3'd3};
    alpha_q  = QOne;
    beta_q   = '0;
    cols_cfg = ColumnsReset;
    acc_sat  = 1'b0;
    for (int i = 0; i < Cols; i++) lane_acc[i] = '0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: unity alpha, zero beta so y is ignored
    send_idle_pct = 20;
    recv_idle_pct = 20;
    pending_rows.push_back(row_of(QOne, QNegOne, QMax, QMin, QOne,
                                  QMax, QMin, $urandom, $urandom, 1'b1));
    // accumulator saturates high
    repeat (2) pending_rows.push_back(row_of(QMin, QMin, QMax, '0, QMin,
                                             '0, '0, '0, '0, 1'b0));
    pending_rows.push_back(row_of('0, '0, '0, '0, '0, '0, '0, '0, '0, 1'b1));
    // accumulator saturates low on the last row
    repeat (2) pending_rows.push_back(row_of(QMin, QMax, QMin, 32'd1, QMax,
                                             '0, '0, '0, '0, 1'b0));
    pending_rows.push_back(row_of(QMin, QMax, QMin, 32'd1, QMax,
                                  '1, '1, '1, '1, 1'b1));
    drain();

    write_reg(RegAlpha, QMax);
    write_reg(RegBeta, QMin);
    write_reg(RegColumns, 32'd4);
    pending_rows.push_back(rand_row(1'b0, 1'b0));
    pending_rows.push_back(row_of(rand_elem(0), rand_elem(0), rand_elem(0), rand_elem(0),
                                  rand_elem(0), QMax, QMin, '0, '1, 1'b1));
    drain();

    // single column, so lanes one to three stay zero
    write_reg(RegAlpha, QMin);
    write_reg(RegBeta, QMax);
    write_reg(RegColumns, 32'd1);
    write_reg(RegSpare, $urandom);
    pending_rows.push_back(rand_row(1'b1, 1'b0));
    pending_rows.push_back(row_of($urandom, $urandom, $urandom, $urandom, $urandom,
                                  QMin, QMax, QMin, QMax, 1'b1));
    drain();

    write_reg(RegAlpha, QOne);
    write_reg(RegBeta, QOne);
    foreach (col_sweep[k]) begin
      write_reg(RegColumns, {29'd0, col_sweep[k]});
      pending_rows.push_back(rand_row(1'b1, 1'b1));
      drain();
    end

    // random phases, each under its own register settings
    for (int p = 0; p < 10; p++) begin
      write_reg(RegAlpha, rand_gain());
      write_reg(RegBeta, ($urandom_range(0, 2) == 0) ? '0 : rand_gain());
      write_reg(RegColumns, $urandom_range(0, 7));
      queued = 0;
      if (p == 4) begin
        // receiver holds off while short matrices keep coming
        send_idle_pct = 0;
        recv_idle_pct = 0;
        long_hold_req = 1'b1;
        while (queued < 100) queued += push_matrix(2, 1'b0);
      end else if (p == 9) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (queued < 80) queued += push_matrix(6, 1'b0);
      end else begin
        send_idle_pct = (p == 2) ? 0 : $urandom_range(5, 40);
        recv_idle_pct = (p == 2) ? 0 : $urandom_range(5, 40);
        while (queued < 70) queued += push_matrix(6, p[0]);
      end
      drain();
      long_hold_req = 1'b0;
    end

    $display("Covered %0d rows and %0d results (%0d flagged overflow), %0d register writes,",
             rows_sent, results_seen, sat_results, reg_writes);
    $display("column counts 0..7, extreme gains and a long output hold-off.");
    if (fail_count == 0) begin
      $display("transposed_matvec_4col_top regression: pass");
    end else begin
      $display("transposed_matvec_4col_top regression: fail");
    end
    $finish;
  end

endmodule
